@@ src/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high
`define AFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked through reset as well
`define AFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/afs_pkg.sv @@
package afs_pkg;

   // Default parameter values
   localparam int MAX_FRAMES_DEF = 4096;
   localparam int FRAC_BITS_DEF  = 16;

   // Fixed field widths
   localparam int REQ_W      = 2;
   localparam int TIME_W     = 32;
   localparam int POS_W      = 28;
   localparam int FRAME_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int SPEED_W    = 25;
   localparam int BLEND_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   // Blend scale: fraction times this value, truncated
   localparam int BLEND_SCALE = 1000;

   // Register reset values
   localparam logic [FRAME_W-1:0]        FIRST_RST = 12'd0;
   localparam logic [FRAME_W-1:0]        LAST_RST  = 12'd4095;
   localparam logic [COUNT_W-1:0]        COUNT_RST = 13'd4096;
   localparam logic signed [SPEED_W-1:0] SPEED_RST = 25'sd1638;
   localparam logic                      LOOP_RST  = 1'b1;

   // Request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_SEEK   = 2'd1,
      REQ_REWIND = 2'd2
   } req_kind_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_FRAME = 3'd0,
      CSR_LAST_FRAME  = 3'd1,
      CSR_FRAME_COUNT = 3'd2,
      CSR_SPEED       = 3'd3,
      CSR_LOOP_ENABLE = 3'd4
   } csr_reg_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SUM,
      ST_DECIDE,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } afs_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic prep;
      logic mul;
      logic sum;
      logic decide;
      logic div_step;
      logic fix;
      logic load;
   } afs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_tick;
      logic single;
      logic need_mod;
      logic div_last;
      logic out_free;
   } afs_stat_type;

endpackage

@@ src/animation_frame_stepper_top.sv @@
// Animation frame stepper.
// Requests arrive on the req_ channel (req_valid / req_stall): a tick with a
// millisecond timestamp, a seek to a fixed-point position, or a rewind.
// Each request produces exactly one transfer on the rsp_ channel carrying the
// frame index, the blend (0..999) and the full position.
// The csr_ port writes range, frame count, speed and loop mode; write it only
// while no request is in flight.
// One request is worked at a time. Seek, rewind, unknown codes and a tick on a
// single-frame range settle in the step-product state and go straight to the
// done state; other ticks pass the sum and decide states, and a tick that wraps
// in loop mode also passes the wrap remainder unit, which retires one quotient
// bit per cycle, and a fix state before the result register is loaded.
// The next request is taken in the cycle after a result is loaded.
// The result sits in an output register; while rsp_stall is high it holds,
// and a finished result waits in the datapath until the register is free.
// Synchronous reset restores register defaults, clears the position and the
// last timestamp (so the next tick measures zero elapsed) and drops rsp_valid.
module animation_frame_stepper_top #(
   parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF,
   parameter int FRAC_BITS  = afs_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [afs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [afs_pkg::REQ_W-1:0]      req_type,
   input  logic [afs_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [afs_pkg::POS_W-1:0]      req_seek_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [afs_pkg::FRAME_W-1:0]    rsp_frame_index,
   output logic [afs_pkg::BLEND_W-1:0]    rsp_frame_blend,
   output logic [afs_pkg::POS_W-1:0]      rsp_position
);

   afs_pkg::afs_cmd_type  cmd;
   afs_pkg::afs_stat_type stat;

   afs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   afs_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_now_ms        (req_now_ms),
      .req_seek_position (req_seek_position),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_frame_blend   (rsp_frame_blend),
      .rsp_position      (rsp_position),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

@@ src/afs_ctrl.sv @@
module afs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  afs_pkg::afs_stat_type stat,
   output afs_pkg::afs_cmd_type  cmd
);

   afs_pkg::afs_state_type state_ff;
   afs_pkg::afs_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request through the datapath
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         afs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = afs_pkg::ST_PREP;
            end
         end
         afs_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = afs_pkg::ST_MUL;
         end
         afs_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            if (stat.is_tick && !stat.single) begin
               state_in = afs_pkg::ST_SUM;
            end else begin
               state_in = afs_pkg::ST_DONE;
            end
         end
         afs_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = afs_pkg::ST_DECIDE;
         end
         afs_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.need_mod) begin
               state_in = afs_pkg::ST_DIV;
            end else begin
               state_in = afs_pkg::ST_DONE;
            end
         end
         afs_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = afs_pkg::ST_FIX;
            end
         end
         afs_pkg::ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = afs_pkg::ST_DONE;
         end
         afs_pkg::ST_DONE: begin
            // Hold until the result register can take the new result
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = afs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = afs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/afs_datapath.sv @@
module afs_datapath #(
   parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF,
   parameter int FRAC_BITS  = afs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [afs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [afs_pkg::REQ_W-1:0]           req_type,
   input  logic [afs_pkg::TIME_W-1:0]          req_now_ms,
   input  logic [afs_pkg::POS_W-1:0]           req_seek_position,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [afs_pkg::FRAME_W-1:0]         rsp_frame_index,
   output logic [afs_pkg::BLEND_W-1:0]         rsp_frame_blend,
   output logic [afs_pkg::POS_W-1:0]           rsp_position,
   input  afs_pkg::afs_cmd_type                cmd,
   output afs_pkg::afs_stat_type               stat
);

   localparam int FRAME_W = afs_pkg::FRAME_W;
   localparam int POS_W   = afs_pkg::POS_W;
   localparam int TIME_W  = afs_pkg::TIME_W;
   localparam int SPEED_W = afs_pkg::SPEED_W;
   localparam int COUNT_W = afs_pkg::COUNT_W;
   localparam int BLEND_W = afs_pkg::BLEND_W;
   // Signed width of position plus elapsed times speed
   localparam int SW   = TIME_W + SPEED_W + 1;
   // Width of a frame number in fixed point
   localparam int FW_F = FRAME_W + FRAC_BITS;
   // Integer bits of the wrap dividend, one per divider step
   localparam int QW   = SW - FRAC_BITS;
   localparam int CW   = $clog2(QW + 1);
   localparam int MCW  = $clog2(MAX_FRAMES + 1);
   localparam int EW   = (MCW > COUNT_W) ? MCW : COUNT_W;
   localparam int BPW  = FRAC_BITS + BLEND_W;

   // Configuration registers
   logic [FRAME_W-1:0]        first_ff, first_in;
   logic [FRAME_W-1:0]        last_ff, last_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      loop_ff, loop_in;

   // Animation state
   logic [POS_W-1:0]          position_ff, position_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;

   // Request and working registers
   afs_pkg::req_kind_type     kind_ff, kind_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic [POS_W-1:0]          seek_ff, seek_in;
   logic [FRAME_W-1:0]        lo_ff, lo_in;
   logic [FRAME_W-1:0]        hi_ff, hi_in;
   logic [FRAME_W-1:0]        span_ff, span_in;
   logic [TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic signed [SW-1:0]      prod_ff, prod_in;
   logic signed [SW-1:0]      sum_ff, sum_in;
   logic [QW-1:0]             q_ff, q_in;
   logic [FRAME_W-1:0]        rem_ff, rem_in;
   logic [FRAC_BITS-1:0]      dfrac_ff, dfrac_in;
   logic [CW-1:0]             cnt_ff, cnt_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [BLEND_W-1:0]        rsp_blend_ff, rsp_blend_in;
   logic [POS_W-1:0]          rsp_position_ff, rsp_position_in;

   // Range and arithmetic terms
   logic [EW-1:0]             fc_e;
   logic [EW-1:0]             maxf_e;
   logic [FRAME_W-1:0]        range_a;
   logic [FRAME_W-1:0]        range_b;
   logic [FW_F-1:0]           lo_f;
   logic [FW_F-1:0]           hi_f;
   logic signed [SW-1:0]      lo_fs;
   logic signed [SW-1:0]      hi_fs;
   logic                      speed_pos;
   logic                      speed_neg;
   logic [TIME_W-1:0]         base_time;
   logic signed [SW-1:0]      seek_ext;
   logic signed [SW-1:0]      seek_clamped;
   logic                      sum_gt_hi;
   logic                      sum_lt_lo;
   logic                      need_mod;
   logic signed [SW-1:0]      keep_sum;
   logic [SW-1:0]             dvd;
   logic [FRAME_W:0]          div_t;
   logic                      div_ge;
   logic [FRAME_W-1:0]        div_rem;
   logic [FW_F-1:0]           wrap_r;
   logic [FW_F:0]             wrap_pos;
   logic [SW-1:0]             pos_ext;
   logic [BPW-1:0]            blend_prod;

   // Order and clamp the requested range
   always_comb begin
      fc_e = EW'(count_ff);
      if (fc_e == '0) begin
         fc_e = EW'(1);
      end
      if (fc_e > EW'(MAX_FRAMES)) begin
         fc_e = EW'(MAX_FRAMES);
      end
      maxf_e = fc_e - EW'(1);
      if (last_ff < first_ff) begin
         range_a = last_ff;
         range_b = first_ff;
      end else begin
         range_a = first_ff;
         range_b = last_ff;
      end
      if (EW'(range_a) > maxf_e) begin
         range_a = FRAME_W'(maxf_e);
      end
      if (EW'(range_b) > maxf_e) begin
         range_b = FRAME_W'(maxf_e);
      end
   end

   assign lo_f      = {lo_ff, {FRAC_BITS{1'b0}}};
   assign hi_f      = {hi_ff, {FRAC_BITS{1'b0}}};
   assign lo_fs     = $signed(SW'(lo_f));
   assign hi_fs     = $signed(SW'(hi_f));
   assign speed_neg = speed_ff[SPEED_W-1];
   assign speed_pos = !speed_neg && (speed_ff != '0);
   assign base_time = (last_time_ff == '0) ? now_ff : last_time_ff;

   // Seek target limited to the range
   assign seek_ext = $signed(SW'(seek_ff));
   always_comb begin
      if (seek_ext < lo_fs) begin
         seek_clamped = lo_fs;
      end else if (seek_ext > hi_fs) begin
         seek_clamped = hi_fs;
      end else begin
         seek_clamped = seek_ext;
      end
   end

   // Range end checks on the advanced position
   assign sum_gt_hi = sum_ff > hi_fs;
   assign sum_lt_lo = sum_ff < lo_fs;
   assign need_mod  = loop_ff && (speed_pos ? sum_gt_hi : sum_lt_lo);

   always_comb begin
      keep_sum = sum_ff;
      if (!loop_ff) begin
         if (speed_pos && sum_gt_hi) begin
            keep_sum = hi_fs;
         end else if (!speed_pos && sum_lt_lo) begin
            keep_sum = lo_fs;
         end
      end
   end

   // Distance from the range end that the wrap starts from
   assign dvd = speed_pos ? $unsigned(sum_ff - lo_fs) : $unsigned(hi_fs - sum_ff);

   // One restoring remainder step over the span in whole frames
   assign div_t   = {rem_ff, q_ff[QW-1]};
   assign div_ge  = div_t >= {1'b0, span_ff};
   assign div_rem = div_ge ? FRAME_W'(div_t - {1'b0, span_ff}) : div_t[FRAME_W-1:0];

   // Rebuild the wrapped position from remainder and fraction
   assign wrap_r   = {rem_ff, dfrac_ff};
   assign wrap_pos = speed_pos ? ({1'b0, lo_f} + {1'b0, wrap_r})
                               : ({1'b0, hi_f} - {1'b0, wrap_r});

   // Result fields from the final position
   assign pos_ext    = SW'(position_ff);
   assign blend_prod = BPW'(position_ff[FRAC_BITS-1:0]) * BPW'(afs_pkg::BLEND_SCALE);

   // Next values
   always_comb begin
      first_in        = first_ff;
      last_in         = last_ff;
      count_in        = count_ff;
      speed_in        = speed_ff;
      loop_in         = loop_ff;
      position_in     = position_ff;
      last_time_in    = last_time_ff;
      kind_in         = kind_ff;
      now_in          = now_ff;
      seek_in         = seek_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      span_in         = span_ff;
      elapsed_in      = elapsed_ff;
      prod_in         = prod_ff;
      sum_in          = sum_ff;
      q_in            = q_ff;
      rem_in          = rem_ff;
      dfrac_in        = dfrac_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_blend_in    = rsp_blend_ff;
      rsp_position_in = rsp_position_ff;

      // Register writes
      if (csr_write) begin
         unique case (afs_pkg::csr_reg_type'(csr_index))
            afs_pkg::CSR_FIRST_FRAME: first_in = csr_wdata[FRAME_W-1:0];
            afs_pkg::CSR_LAST_FRAME:  last_in  = csr_wdata[FRAME_W-1:0];
            afs_pkg::CSR_FRAME_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            afs_pkg::CSR_SPEED:       speed_in = $signed(csr_wdata[SPEED_W-1:0]);
            afs_pkg::CSR_LOOP_ENABLE: loop_in  = csr_wdata[0];
            default: ;
         endcase
      end

      // Capture the request
      if (cmd.accept) begin
         kind_in = afs_pkg::req_kind_type'(req_type);
         now_in  = req_now_ms;
         seek_in = req_seek_position;
      end

      // Range and elapsed time
      if (cmd.prep) begin
         lo_in   = range_a;
         hi_in   = range_b;
         span_in = range_b - range_a;
         if (kind_ff == afs_pkg::REQ_TICK) begin
            elapsed_in   = now_ff - base_time;
            last_time_in = now_ff;
         end
      end

      // Step product; seek, rewind and single-frame range settle here
      if (cmd.mul) begin
         prod_in = $signed({1'b0, elapsed_ff}) * speed_ff;
         unique case (kind_ff)
            afs_pkg::REQ_TICK: begin
               if (lo_ff == hi_ff) begin
                  position_in = POS_W'(lo_f);
               end
            end
            afs_pkg::REQ_SEEK: begin
               position_in = POS_W'(seek_clamped);
            end
            afs_pkg::REQ_REWIND: begin
               position_in = speed_neg ? POS_W'(hi_f) : POS_W'(lo_f);
            end
            default: ;
         endcase
      end

      // Advance the position
      if (cmd.sum) begin
         sum_in = prod_ff + $signed(SW'(position_ff));
      end

      // Clamp, keep, or start the wrap
      if (cmd.decide) begin
         if (need_mod) begin
            q_in     = dvd[SW-1:FRAC_BITS];
            dfrac_in = dvd[FRAC_BITS-1:0];
            rem_in   = '0;
            cnt_in   = CW'(QW);
         end else if (keep_sum[SW-1]) begin
            position_in = '0;
         end else begin
            position_in = POS_W'(keep_sum);
         end
      end

      if (cmd.div_step) begin
         rem_in = div_rem;
         q_in   = q_ff << 1;
         cnt_in = cnt_ff - CW'(1);
      end

      if (cmd.fix) begin
         position_in = POS_W'(wrap_pos);
      end

      // Result register: drop on transfer, load a new result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         rsp_valid_in    = 1'b1;
         rsp_index_in    = pos_ext[FRAC_BITS +: FRAME_W];
         rsp_blend_in    = blend_prod[FRAC_BITS +: BLEND_W];
         rsp_position_in = position_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= afs_pkg::FIRST_RST;
         last_ff      <= afs_pkg::LAST_RST;
         count_ff     <= afs_pkg::COUNT_RST;
         speed_ff     <= afs_pkg::SPEED_RST;
         loop_ff      <= afs_pkg::LOOP_RST;
         position_ff  <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         speed_ff     <= speed_in;
         loop_ff      <= loop_in;
         position_ff  <= position_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      now_ff          <= now_in;
      seek_ff         <= seek_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      span_ff         <= span_in;
      elapsed_ff      <= elapsed_in;
      prod_ff         <= prod_in;
      sum_ff          <= sum_in;
      q_ff            <= q_in;
      rem_ff          <= rem_in;
      dfrac_ff        <= dfrac_in;
      cnt_ff          <= cnt_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_blend_ff    <= rsp_blend_in;
      rsp_position_ff <= rsp_position_in;
   end

   // Status to the controller
   assign stat.is_tick  = kind_ff == afs_pkg::REQ_TICK;
   assign stat.single   = lo_ff == hi_ff;
   assign stat.need_mod = need_mod;
   assign stat.div_last = cnt_ff == CW'(1);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_index_ff;
   assign rsp_frame_blend = rsp_blend_ff;
   assign rsp_position    = rsp_position_ff;

endmodule

@@ src/afs_checker.sv @@
`include "assert_macros.svh"

module afs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [afs_pkg::BLEND_W-1:0] rsp_frame_blend,
   input logic [afs_pkg::POS_W-1:0]   rsp_position
);

   // Reset leaves the block ready with no result pending
   `AFS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")

   // One request at a time: a transfer in closes the input
   `AFS_ASSERT(a_one_at_a_time, clock, reset, req_valid && !req_stall |=> req_stall, "second request taken while busy")

   // A new result only appears while a request is in flight
   `AFS_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "result without request")

   // A stalled result holds
   `AFS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position), "stalled result changed")

   // Blend stays below one thousand
   `AFS_ASSERT(a_blend_range, clock, reset, rsp_valid |-> rsp_frame_blend <= 10'd999, "blend out of range")

endmodule

bind animation_frame_stepper_top afs_checker u_afs_checker (.*);
